@@ sv/mvm_pkg.sv @@
// Shared constants, codes and the command type of the matrix-vector multiplier.
package mvm_pkg;

	localparam int MAX_COLS    = 256;
	localparam int MAX_ROWS    = 4096;
	localparam int DATA_WIDTH  = 16;
	localparam int COL_W       = $clog2(MAX_COLS);
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int NCOL_W      = 9;
	localparam int NROW_W      = 13;
	localparam int SUM_W       = 40;
	localparam int PROD_W      = 2 * DATA_WIDTH;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Item opcodes.
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_MATRIX = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_NUM_ROWS = 1'b0;
	localparam logic CFG_NUM_COLS = 1'b1;

	// One classified item, passed from the front end to the back end.
	typedef struct packed {
		logic                         is_load;
		logic [COL_W-1:0]             addr;
		logic signed [DATA_WIDTH-1:0] data;
		logic                         end_row;
		logic [ROW_W-1:0]             row;
		logic                         last;
	} cmd_t;

endpackage

@@ sv/mvm_front.sv @@
// Front end: configuration registers, item transfer and classification into commands.
module mvm_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic                                 opcode,
	input  logic signed [mvm_pkg::DATA_WIDTH-1:0] element_value,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_index,
	input  logic [mvm_pkg::NROW_W-1:0]           cfg_data,
	input  logic                                 queue_full,
	output logic                                 push,
	output mvm_pkg::cmd_t                        push_cmd
);
	import mvm_pkg::*;

	logic [NROW_W-1:0] num_rows_q;
	logic [NCOL_W-1:0] num_cols_q;
	logic [COL_W-1:0]  load_ptr_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;

	logic [NCOL_W-1:0] cols_eff;
	logic [NROW_W-1:0] rows_eff;
	logic [NCOL_W-1:0] ptr_inc;
	logic [NCOL_W-1:0] col_cur;
	logic [NCOL_W-1:0] col_inc;
	logic [NROW_W-1:0] row_inc;
	logic              end_row;
	logic              last;

	assign cfg_ready  = 1'b1;
	assign item_stall = queue_full;
	assign push       = item_valid && !queue_full;

	// Out-of-range register values are clamped to the legal range.
	always_comb begin
		if (num_cols_q == '0) begin
			cols_eff = NCOL_W'(1);
		end else if (num_cols_q > NCOL_W'(MAX_COLS)) begin
			cols_eff = NCOL_W'(MAX_COLS);
		end else begin
			cols_eff = num_cols_q;
		end
		if (num_rows_q == '0) begin
			rows_eff = NROW_W'(1);
		end else if (num_rows_q > NROW_W'(MAX_ROWS)) begin
			rows_eff = NROW_W'(MAX_ROWS);
		end else begin
			rows_eff = num_rows_q;
		end
	end

	// Column position, end of row and final row of the current matrix element.
	always_comb begin
		ptr_inc = NCOL_W'(load_ptr_q) + NCOL_W'(1);
		col_cur = NCOL_W'(col_q);
		if (col_cur >= cols_eff) begin
			col_cur = cols_eff - NCOL_W'(1);
		end
		col_inc = col_cur + NCOL_W'(1);
		end_row = col_inc >= cols_eff;
		row_inc = NROW_W'(row_q) + NROW_W'(1);
		last    = row_inc >= rows_eff;
	end

	// Command for the back end.
	always_comb begin
		push_cmd.is_load = (opcode == OP_LOAD);
		push_cmd.addr    = (opcode == OP_LOAD) ? load_ptr_q : col_cur[COL_W-1:0];
		push_cmd.data    = element_value;
		push_cmd.end_row = end_row;
		push_cmd.row     = row_q;
		push_cmd.last    = last;
	end

	// Configuration registers and stream position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= NROW_W'(1);
			num_cols_q <= NCOL_W'(1);
			load_ptr_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_NUM_ROWS: num_rows_q <= cfg_data;
					CFG_NUM_COLS: num_cols_q <= cfg_data[NCOL_W-1:0];
					default:      num_rows_q <= num_rows_q;
				endcase
			end
			if (push) begin
				if (opcode == OP_LOAD) begin
					load_ptr_q <= (ptr_inc >= cols_eff) ? '0 : ptr_inc[COL_W-1:0];
				end else if (!end_row) begin
					col_q <= col_inc[COL_W-1:0];
				end else begin
					col_q <= '0;
					row_q <= last ? '0 : row_inc[ROW_W-1:0];
				end
			end
		end
	end

endmodule

@@ sv/mvm_queue.sv @@
// Short command queue between the front end and the back end.
module mvm_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mvm_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output mvm_pkg::cmd_t pop_cmd
);
	import mvm_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

@@ sv/mvm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/mvm_back.sv @@
// Back end: vector store, multiply-accumulate pipeline and result register.
module mvm_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 empty,
	input  mvm_pkg::cmd_t                        pop_cmd,
	output logic                                 pop,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [mvm_pkg::SUM_W-1:0]     row_result,
	output logic [mvm_pkg::ROW_W-1:0]            row_index,
	output logic                                 last_row
);
	import mvm_pkg::*;

	logic                         advance;
	logic                         mat_issue;
	logic [DATA_WIDTH-1:0]        vec_rdata;

	logic                         valid_s1;
	logic signed [DATA_WIDTH-1:0] a_s1;
	logic                         end_s1;
	logic [ROW_W-1:0]             row_s1;
	logic                         last_s1;

	logic                         valid_s2;
	logic signed [PROD_W-1:0]     prod_s2;
	logic                         end_s2;
	logic [ROW_W-1:0]             row_s2;
	logic                         last_s2;

	logic signed [SUM_W-1:0]      sum_q;
	logic signed [SUM_W-1:0]      sum_next;
	logic                         out_valid_q;

	// The whole pipeline moves unless a finished result is held by the consumer.
	assign advance      = !(out_valid_q && result_stall);
	assign pop          = advance && !empty;
	assign mat_issue    = pop && !pop_cmd.is_load;
	assign result_valid = out_valid_q;
	assign sum_next     = sum_q + SUM_W'(prod_s2);

	mvm_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (MAX_COLS)
	) u_vec_ram (
		.clk   (clk),
		.we    (pop && pop_cmd.is_load),
		.waddr (pop_cmd.addr),
		.wdata (pop_cmd.data),
		.re    (mat_issue),
		.raddr (pop_cmd.addr),
		.rdata (vec_rdata)
	);

	// Payload of the multiply stages and the row result register.
	always_ff @(posedge clk) begin
		if (advance) begin
			a_s1    <= pop_cmd.data;
			end_s1  <= pop_cmd.end_row;
			row_s1  <= pop_cmd.row;
			last_s1 <= pop_cmd.last;
			prod_s2 <= a_s1 * $signed(vec_rdata);
			end_s2  <= end_s1;
			row_s2  <= row_s1;
			last_s2 <= last_s1;
		end
		if (advance && valid_s2 && end_s2) begin
			row_result <= sum_next;
			row_index  <= row_s2;
			last_row   <= last_s2;
		end
	end

	// Stage valids, running sum and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1 <= mat_issue;
				valid_s2 <= valid_s1;
				if (valid_s2) begin
					sum_q <= end_s2 ? '0 : sum_next;
				end
				out_valid_q <= valid_s2 && end_s2;
			end
		end
	end

endmodule

@@ sv/matrix_vector_multiply.sv @@
// Top level of the streaming dense matrix-vector multiplier.
//
//   Channel   Handshake              Payload
//   item      item_valid/item_stall  opcode, element_value
//   result    result_valid/stall     row_result, row_index, last_row
//   config    cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One item is taken per cycle while the queue is not full; a row result is
// offered after its last matrix element has passed the queue pop with vector
// RAM read, the multiply and the accumulate into the result register. The
// vector RAM has one write and one read port, so loads and matrix elements
// share the one-per-cycle issue slot. Reset clears counters, the running sum
// and valids; the vector store holds no reset value. A stalled result holds the
// back end; the four-entry queue absorbs items until full.
module matrix_vector_multiply (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic                                 opcode,
	input  logic signed [mvm_pkg::DATA_WIDTH-1:0] element_value,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [mvm_pkg::SUM_W-1:0]     row_result,
	output logic [mvm_pkg::ROW_W-1:0]            row_index,
	output logic                                 last_row,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_index,
	input  logic [mvm_pkg::NROW_W-1:0]           cfg_data
);
	import mvm_pkg::*;

	logic queue_full;
	logic queue_empty;
	logic push;
	logic pop;
	cmd_t push_cmd;
	cmd_t pop_cmd;

	mvm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.opcode        (opcode),
		.element_value (element_value),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.queue_full    (queue_full),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	mvm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (queue_full),
		.pop      (pop),
		.empty    (queue_empty),
		.pop_cmd  (pop_cmd)
	);

	mvm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (queue_empty),
		.pop_cmd      (pop_cmd),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.row_result   (row_result),
		.row_index    (row_index),
		.last_row     (last_row)
	);

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the matrix-vector multiplier: directed and random item streams.
module tb;
	import mvm_pkg::*;

	localparam int HALF_PERIOD    = 4;
	localparam int RESET_CYCLES   = 8;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEM_TARGET    = 1700;
	localparam int PHASE_BUDGET   = 320;
	localparam int PRINT_LIMIT    = 100;

	// One expected row of y = A * x.
	typedef struct {
		logic [SUM_W-1:0] total;
		logic [ROW_W-1:0] row;
		logic             last;
	} row_sum_t;

	// Tracks the vector store, the counters and the running sum, and scores row results.
	class mvm_scoreboard;
		logic [NROW_W-1:0]            rows_reg;
		logic [NCOL_W-1:0]            cols_reg;
		logic signed [DATA_WIDTH-1:0] vec_mem [MAX_COLS];
		bit                           vec_written [MAX_COLS];
		int                           load_ptr;
		int                           col_cnt;
		int                           row_cnt;
		logic [SUM_W-1:0]             acc;
		row_sum_t                     expected_rows [$];
		int                           loads_seen;
		int                           elements_seen;
		int                           rows_checked;
		int                           mismatches;

		function new();
			rows_reg      = 1;
			cols_reg      = 1;
			load_ptr      = 0;
			col_cnt       = 0;
			row_cnt       = 0;
			acc           = '0;
			loads_seen    = 0;
			elements_seen = 0;
			rows_checked  = 0;
			mismatches    = 0;
			foreach (vec_written[i]) begin
				vec_written[i] = 1'b0;
				vec_mem[i]     = '0;
			end
		endfunction

		// A zero count acts as one; counts above the maximum act as the maximum.
		function int eff_cols();
			if (cols_reg == 0) return 1;
			if (cols_reg > MAX_COLS) return MAX_COLS;
			return int'(cols_reg);
		endfunction

		function int eff_rows();
			if (rows_reg == 0) return 1;
			if (rows_reg > MAX_ROWS) return MAX_ROWS;
			return int'(rows_reg);
		endfunction

		// Column entry the next matrix element multiplies with.
		function int read_column();
			int c;
			c = col_cnt;
			if (c >= eff_cols()) c = eff_cols() - 1;
			return c;
		endfunction

		function bit can_stream();
			return vec_written[read_column()];
		endfunction

		function int items_seen();
			return loads_seen + elements_seen;
		endfunction

		function void write_reg(logic idx, logic [NROW_W-1:0] data);
			if (idx == CFG_NUM_ROWS) begin
				rows_reg = data;
			end else begin
				cols_reg = data[NCOL_W-1:0];
			end
		endfunction

		// Applies one transferred item and queues the row sum it completes, if any.
		function void note_item(logic op, logic signed [DATA_WIDTH-1:0] value);
			int       cols;
			int       c;
			longint   prod;
			row_sum_t r;
			cols = eff_cols();
			if (op == OP_LOAD) begin
				vec_mem[load_ptr % MAX_COLS]     = value;
				vec_written[load_ptr % MAX_COLS] = 1'b1;
				load_ptr = (load_ptr + 1 >= cols) ? 0 : load_ptr + 1;
				loads_seen++;
				return;
			end
			elements_seen++;
			c    = read_column();
			prod = longint'(value) * longint'(vec_mem[c]);
			acc  = acc + SUM_W'(prod);
			if (c + 1 < cols) begin
				col_cnt = c + 1;
				return;
			end
			r.total = acc;
			r.row   = ROW_W'(row_cnt);
			r.last  = (row_cnt + 1 >= eff_rows());
			expected_rows.push_back(r);
			acc     = '0;
			col_cnt = 0;
			row_cnt = r.last ? 0 : row_cnt + 1;
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, what);
		endtask

		task check_row(logic [SUM_W-1:0] total, logic [ROW_W-1:0] row, logic last);
			row_sum_t exp_row;
			if (expected_rows.size() == 0) begin
				report($sformatf("row result %0d for row %0d with no row pending",
					$signed(total), row));
				return;
			end
			exp_row = expected_rows.pop_front();
			rows_checked++;
			if (total !== exp_row.total)
				report($sformatf("row %0d: row_result %0d, expected %0d", exp_row.row,
					$signed(total), $signed(exp_row.total)));
			if (row !== exp_row.row)
				report($sformatf("row_index %0d, expected %0d", row, exp_row.row));
			if (last !== exp_row.last)
				report($sformatf("row %0d: last_row %b, expected %b", exp_row.row, last,
					exp_row.last));
		endtask
	endclass

	logic                         clk           = 1'b0;
	logic                         arst_n        = 1'b0;
	logic                         item_valid    = 1'b0;
	logic                         item_stall;
	logic                         opcode        = OP_LOAD;
	logic signed [DATA_WIDTH-1:0] element_value = '0;
	logic                         result_valid;
	logic                         result_stall  = 1'b0;
	logic signed [SUM_W-1:0]      row_result;
	logic [ROW_W-1:0]             row_index;
	logic                         last_row;
	logic                         cfg_valid     = 1'b0;
	logic                         cfg_ready;
	logic                         cfg_index     = CFG_NUM_ROWS;
	logic [NROW_W-1:0]            cfg_data      = '0;

	mvm_scoreboard sb = new();
	int burst_left   = 0;
	int stall_mode   = 0;
	int stall_left   = 0;
	int quiet_cycles = 0;
	int cfg_writes   = 0;
	int phase_no     = 0;

	matrix_vector_multiply u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.element_value(element_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.row_result   (row_result),
		.row_index    (row_index),
		.last_row     (last_row),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Score every row result transfer.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			sb.check_row(row_result, row_index, last_row);
		end
	end

	// The receiver switches between stall patterns: none, light, heavy and periodic.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 300);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 4) == 0);
			2: result_stall <= ($urandom_range(0, 9) < 7);
			default: result_stall <= (stall_left % 8 < 3);
		endcase
	end

	// End the run when no transfer happens on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles, %0d rows still pending",
				quiet_cycles, sb.expected_rows.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic signed [DATA_WIDTH-1:0] pick_value(bit extreme);
		if (!extreme) return DATA_WIDTH'($urandom);
		case ($urandom_range(0, 4))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return -16'sd1;
			default: return 16'sd1;
		endcase
	endfunction

	// Sends one item in bursts with random gaps. A matrix element that would read a
	// vector entry never loaded is turned into a load instead.
	task automatic send_element(logic op, logic signed [DATA_WIDTH-1:0] value);
		int gap;
		if (op == OP_MATRIX && !sb.can_stream()) op = OP_LOAD;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if ($urandom_range(0, 19) == 0) gap = $urandom_range(20, 40);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
			                                         : $urandom_range(1, 24);
		end
		burst_left--;
		item_valid    <= 1'b1;
		opcode        <= op;
		element_value <= value;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sb.note_item(op, value);
		@(negedge clk);
	endtask

	// Stops sending and waits until every row has come out and the pipeline is empty.
	task automatic settle();
		item_valid <= 1'b0;
		while (sb.expected_rows.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Writes the chosen registers in random order; called only while the block is idle.
	task automatic set_config(bit wr_rows, logic [NROW_W-1:0] rows_v,
	                          bit wr_cols, logic [NROW_W-1:0] cols_v);
		bit                cols_first;
		logic              idx;
		logic [NROW_W-1:0] wdata;
		cols_first = $urandom_range(0, 1);
		for (int k = 0; k < 2; k++) begin
			idx = ((k == 1) != cols_first) ? CFG_NUM_COLS : CFG_NUM_ROWS;
			if (idx == CFG_NUM_ROWS ? !wr_rows : !wr_cols) continue;
			wdata = (idx == CFG_NUM_ROWS) ? rows_v : cols_v;
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= wdata;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			sb.write_reg(idx, wdata);
			cfg_writes++;
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// One random phase: a new shape, usually a fresh vector, then rows of matrix elements.
	// The first phases pin the largest, smallest and out-of-range shapes.
	task automatic run_phase(int phase);
		logic [NROW_W-1:0] rows_v;
		logic [NROW_W-1:0] cols_v;
		bit                wr_rows;
		bit                wr_cols;
		bit                extreme;
		bit                reload;
		int                shape;
		int                cols;
		int                count;
		wr_rows = 1'b1;
		wr_cols = 1'b1;
		reload  = 1'b1;
		shape   = $urandom_range(0, 9);
		extreme = ($urandom_range(0, 4) == 0);
		case (phase)
			0: begin
				rows_v  = NROW_W'(MAX_ROWS);
				cols_v  = NROW_W'(MAX_COLS);
				extreme = 1'b1;
				shape   = 3;
			end
			1: begin
				rows_v = 1;
				cols_v = 1;
				shape  = 3;
			end
			2: begin
				rows_v = 0;
				cols_v = 0;
				shape  = 3;
			end
			3: begin
				// Both counts above their maximum; no fresh vector is loaded, so the entries left by earlier phases are used.
				rows_v = '1;
				cols_v = '1;
				reload = 1'b0;
				shape  = 3;
			end
			default: begin
				case ($urandom_range(0, 15))
					0: rows_v = 1;
					1: rows_v = NROW_W'(MAX_ROWS);
					2: rows_v = 0;
					3: rows_v = NROW_W'($urandom_range(MAX_ROWS + 1, 8191));
					4: rows_v = NROW_W'($urandom_range(1, MAX_ROWS));
					default: rows_v = NROW_W'($urandom_range(1, 6));
				endcase
				case ($urandom_range(0, 15))
					0: cols_v = 1;
					1: cols_v = NROW_W'(MAX_COLS);
					2: cols_v = 0;
					3: cols_v = NROW_W'($urandom_range(MAX_COLS + 1, 511));
					4: cols_v = NROW_W'($urandom_range(1, MAX_COLS));
					default: cols_v = NROW_W'($urandom_range(1, 16));
				endcase
				// Bits above the column count field are ignored by the block.
				if ($urandom_range(0, 3) == 0)
					cols_v[NROW_W-1:NCOL_W] = (NROW_W - NCOL_W)'($urandom);
				wr_rows = ($urandom_range(0, 3) != 0);
				wr_cols = ($urandom_range(0, 3) != 0);
				reload  = ($urandom_range(0, 3) != 0);
			end
		endcase
		settle();
		set_config(wr_rows, rows_v, wr_cols, cols_v);
		cols = sb.eff_cols();
		if (shape == 0) begin
			// Noise: loads and matrix elements mixed at random.
			repeat (40) begin
				send_element($urandom_range(0, 1) ? OP_MATRIX : OP_LOAD, pick_value(extreme));
			end
		end else begin
			if (reload) begin
				repeat (cols) send_element(OP_LOAD, pick_value(extreme));
			end
			count = PHASE_BUDGET / cols;
			if (count < 1) count = 1;
			if (count > sb.eff_rows()) count = sb.eff_rows();
			count = count * cols;
			// Some phases stop anywhere, leaving the counters mid-row for the next shape.
			if (shape == 1) count = $urandom_range(1, count + cols);
			repeat (count) begin
				send_element(($urandom_range(0, 39) == 0) ? OP_LOAD : OP_MATRIX,
					pick_value(extreme));
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset shape of one row by one column, with extreme operands.
		send_element(OP_LOAD, 16'sh7FFF);
		send_element(OP_MATRIX, 16'sh8000);
		send_element(OP_MATRIX, 16'sh7FFF);

		// Two rows of four columns.
		settle();
		set_config(1'b1, 2, 1'b1, 4);
		send_element(OP_LOAD, 16'sh8000);
		send_element(OP_LOAD, 16'sh8000);
		send_element(OP_LOAD, 16'sh7FFF);
		send_element(OP_LOAD, 1);
		repeat (4) send_element(OP_MATRIX, 16'sh8000);
		send_element(OP_MATRIX, 16'sh7FFF);
		send_element(OP_MATRIX, 0);
		send_element(OP_MATRIX, -1);
		send_element(OP_MATRIX, 16'sh8000);

		// Shrink the column count while a row is half done; the next element ends it.
		send_element(OP_MATRIX, 5);
		send_element(OP_MATRIX, -7);
		settle();
		set_config(1'b0, 0, 1'b1, 2);
		send_element(OP_MATRIX, 3);

		// Shrink the row count below the current row; that row becomes the final one.
		settle();
		set_config(1'b1, 1, 1'b0, 0);
		send_element(OP_MATRIX, 9);
		send_element(OP_MATRIX, -9);

		// Leave the load pointer past a smaller column count; it writes and then wraps.
		settle();
		set_config(1'b0, 0, 1'b1, 4);
		send_element(OP_LOAD, 100);
		send_element(OP_LOAD, 200);
		send_element(OP_LOAD, 300);
		settle();
		set_config(1'b0, 0, 1'b1, 2);
		send_element(OP_LOAD, -300);

		while (sb.items_seen() < ITEM_TARGET) begin
			run_phase(phase_no);
			phase_no++;
		end

		settle();
		$display("Covered %0d vector loads and %0d matrix elements over %0d shapes.",
			sb.loads_seen, sb.elements_seen, phase_no + 5);
		$display("%0d register writes, %0d row sums checked, %0d mismatches.", cfg_writes,
			sb.rows_checked, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
